@@ src/mqsb_pkg.sv @@
// Package for the shared-buffer multi-queue block: command beat type, codes, defaults.
// Depends on nothing; used by mqsb_front, mqsb_back and the top level.
package mqsb_pkg;

    localparam int NUM_QUEUES_DEF  = 4;
    localparam int STORE_DEPTH_DEF = 256;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic        kind;
        logic        q_ok;
        logic [1:0]  queue_select;
        logic [31:0] push_value;
    } cmd_t;

endpackage

@@ src/mqsb_front.sv @@
// Front end: accepts input beats, checks the queue number, holds a 2-entry command queue.
// Depends on mqsb_pkg.
module mqsb_front #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 kind,
    input  logic [1:0]           queue_select,
    input  logic signed [31:0]   push_value,
    output logic                 cmd_valid,
    output mqsb_pkg::cmd_t       cmd,
    input  logic                 cmd_take
);
    import mqsb_pkg::*;

    cmd_t       entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_en;
    logic       rd_en;
    cmd_t       in_cmd;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = entry_reg[rptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        in_cmd.kind         = kind;
        in_cmd.q_ok         = (32'(queue_select) < NUM_QUEUES);
        in_cmd.queue_select = queue_select;
        in_cmd.push_value   = push_value;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rd_en)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

@@ src/mqsb_back.sv @@
// Back end: queue head/tail, link and value stores, free-entry stack, 2-entry result queue.
// Depends on mqsb_pkg.
module mqsb_back #(
    parameter int NUM_QUEUES  = mqsb_pkg::NUM_QUEUES_DEF,
    parameter int STORE_DEPTH = mqsb_pkg::STORE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  mqsb_pkg::cmd_t       cmd,
    output logic                 cmd_take,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   pop_value,
    output logic [1:0]           status
);
    import mqsb_pkg::*;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = AW + 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ACCESS = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0] head_mem [NUM_QUEUES];
    logic [AW-1:0] tail_mem [NUM_QUEUES];
    logic [31:0]   val_mem  [STORE_DEPTH];
    logic [AW-1:0] link_mem [STORE_DEPTH];

    cmd_t            cmd_reg;
    logic [QW-1:0]   qi_reg;
    logic [QW-1:0]   qi_in;
    logic [AW-1:0]   head_rd;
    logic [AW-1:0]   tail_rd;
    logic [31:0]     val_rd;
    logic [AW-1:0]   link_rd;
    logic [AW-1:0]   link_raddr;

    logic [NUM_QUEUES-1:0] nonempty_reg, nonempty_next;
    logic [AW-1:0]   stack_top_reg, stack_top_next;
    logic [CW-1:0]   stack_cnt_reg, stack_cnt_next;
    logic [CW-1:0]   fresh_reg, fresh_next;

    logic            head_we, tail_we, val_we, link_we;
    logic [AW-1:0]   head_wdata, tail_wdata, link_waddr, link_wdata, idx;
    logic            ne, ok;
    logic [31:0]     res_value;
    logic [1:0]      res_status;

    logic [31:0]     rq_value_reg  [2];
    logic [1:0]      rq_status_reg [2];
    logic            rq_wptr_reg, rq_rptr_reg;
    logic [1:0]      rq_cnt_reg;
    logic            rq_push, rq_pop;

    assign qi_in    = cmd.q_ok ? QW'(cmd.queue_select) : '0;
    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid && (rq_cnt_reg != 2'd2);
    assign link_raddr = (cmd_reg.kind == KIND_POP) ? head_rd : stack_top_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (cmd_take) state_next = ST_ACCESS;
            ST_ACCESS: state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        nonempty_next  = nonempty_reg;
        stack_top_next = stack_top_reg;
        stack_cnt_next = stack_cnt_reg;
        fresh_next     = fresh_reg;
        head_we        = 1'b0;
        tail_we        = 1'b0;
        val_we         = 1'b0;
        link_we        = 1'b0;
        head_wdata     = '0;
        tail_wdata     = '0;
        link_waddr     = '0;
        link_wdata     = '0;
        idx            = '0;
        res_value      = '0;
        res_status     = STATUS_OK;
        rq_push        = 1'b0;
        ne             = nonempty_reg[qi_reg];
        ok             = 1'b0;
        if (state_reg == ST_COMMIT)
        begin
            rq_push = 1'b1;
            if (cmd_reg.kind == KIND_PUSH)
            begin
                ok = cmd_reg.q_ok &&
                     !((stack_cnt_reg == '0) && (fresh_reg == CW'(STORE_DEPTH)));
                if (!ok)
                begin
                    res_status = STATUS_FULL;
                end
                else
                begin
                    if (stack_cnt_reg != '0)
                    begin
                        idx            = stack_top_reg;
                        stack_top_next = link_rd;
                        stack_cnt_next = stack_cnt_reg - CW'(1);
                    end
                    else
                    begin
                        idx        = fresh_reg[AW-1:0];
                        fresh_next = fresh_reg + CW'(1);
                    end
                    val_we     = 1'b1;
                    tail_we    = 1'b1;
                    tail_wdata = idx;
                    if (!ne)
                    begin
                        head_we             = 1'b1;
                        head_wdata          = idx;
                        nonempty_next[qi_reg] = 1'b1;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = tail_rd;
                        link_wdata = idx;
                    end
                end
            end
            else
            begin
                ok = cmd_reg.q_ok && ne;
                if (!ok)
                begin
                    res_status = STATUS_EMPTY;
                end
                else
                begin
                    idx       = head_rd;
                    res_value = val_rd;
                    if (head_rd == tail_rd)
                    begin
                        nonempty_next[qi_reg] = 1'b0;
                    end
                    else
                    begin
                        head_we    = 1'b1;
                        head_wdata = link_rd;
                    end
                    link_we        = 1'b1;
                    link_waddr     = idx;
                    link_wdata     = stack_top_reg;
                    stack_top_next = idx;
                    stack_cnt_next = stack_cnt_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
            qi_reg  <= qi_in;
            head_rd <= head_mem[qi_in];
            tail_rd <= tail_mem[qi_in];
        end
        if (head_we)
        begin
            head_mem[qi_reg] <= head_wdata;
        end
        if (tail_we)
        begin
            tail_mem[qi_reg] <= tail_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[idx] <= cmd_reg.push_value;
        end
        if (state_reg == ST_ACCESS)
        begin
            val_rd <= val_mem[head_rd];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (state_reg == ST_ACCESS)
        begin
            link_rd <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nonempty_reg  <= '0;
            stack_top_reg <= '0;
            stack_cnt_reg <= '0;
            fresh_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            nonempty_reg  <= nonempty_next;
            stack_top_reg <= stack_top_next;
            stack_cnt_reg <= stack_cnt_next;
            fresh_reg     <= fresh_next;
        end
    end

    // result queue
    assign empty     = (rq_cnt_reg == 2'd0);
    assign rq_pop    = pop && !empty;
    assign pop_value = rq_value_reg[rq_rptr_reg];
    assign status    = rq_status_reg[rq_rptr_reg];

    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_value_reg[rq_wptr_reg]  <= res_value;
            rq_status_reg[rq_wptr_reg] <= res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wptr_reg <= 1'b0;
            rq_rptr_reg <= 1'b0;
            rq_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (rq_push)
            begin
                rq_wptr_reg <= !rq_wptr_reg;
            end
            if (rq_pop)
            begin
                rq_rptr_reg <= !rq_rptr_reg;
            end
            rq_cnt_reg <= rq_cnt_reg + 2'(rq_push) - 2'(rq_pop);
        end
    end

endmodule

@@ src/multi_queue_shared_buffer_top.sv @@
// Top level of the shared-buffer multi-queue block: front end, command queue, back end.
// Depends on mqsb_pkg, mqsb_front, mqsb_back.
//
// Usage:
//   Input channel is a queue write port: drive kind, queue_select, push_value and
//   raise push; the beat is taken on a clock edge with push high and full low.
//   kind selects push of push_value onto queue queue_select, or pop from it.
//   Result channel is a queue read port: while empty is low, pop_value and status
//   show the oldest result; it is taken on an edge with pop high and empty low.
//   Every input beat yields exactly one result beat, in order.
//   Status: ok, store full (push), queue empty (pop); out-of-range queue numbers
//   answer full on push and empty on pop.
//   The back end finishes one beat before taking the next, by its sequence of
//   head/tail lookup, link/value store read, then store and pointer write.
//   Up to two commands and two results are buffered, so input keeps flowing for a
//   while when the result side stalls; then full rises until pop resumes.
//   Reset: all queues empty, every entry free; no clearing pass, ready at once.
module multi_queue_shared_buffer_top #(
    parameter int NUM_QUEUES  = mqsb_pkg::NUM_QUEUES_DEF,
    parameter int STORE_DEPTH = mqsb_pkg::STORE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               kind,
    input  logic [1:0]         queue_select,
    input  logic signed [31:0] push_value,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] pop_value,
    output logic [1:0]         status
);
    import mqsb_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    mqsb_front #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .queue_select (queue_select),
        .push_value   (push_value),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take)
    );

    mqsb_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .pop_value (pop_value),
        .status    (status)
    );

endmodule
